// ===== rtl/midi_byte_to_ble_packet_framer_macros.svh =====
// Assertion macros shared by the framer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the user's scope.
`ifndef MIDI_BYTE_TO_BLE_PACKET_FRAMER_MACROS_SVH
`define MIDI_BYTE_TO_BLE_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mbf_pkg.sv =====
// Package for the MIDI to BLE packet framer: constants and the message length decode.
// No dependencies.
`timescale 1ns / 1ps
package mbf_pkg;

	localparam int MBF_BUFFER_BYTES = 16;

	localparam logic [7:0] MBF_SYSEX_END = 8'hF7;
	localparam logic [7:0] MBF_HDR_MARK  = 8'h80;

	// Length of a message decided by its first byte; zero means it never completes.
	function automatic logic [1:0] mbf_msg_length(input logic [7:0] s);
		logic [1:0] len;
		len = 2'd0;
		if (s >= 8'hF4 || s == 8'hF1 || s == MBF_SYSEX_END) begin
			len = 2'd1;
		end else if ((s >= 8'hC0 && s <= 8'hDF) || s == 8'hF3) begin
			len = 2'd2;
		end else if ((s >= 8'h80 && s <= 8'hBF) || (s >= 8'hE0 && s <= 8'hEF) || s == 8'hF2) begin
			len = 2'd3;
		end
		return len;
	endfunction

endpackage

// ===== rtl/midi_byte_to_ble_packet_framer.sv =====
// Channel   Dir  Data                                   Last         User
// s_axis    in   [7:0] midi_byte, [20:8] time_ms         -            -
// m_axis    out  [7:0] packet_byte                       packet_end   run_last
//
// An input beat that completes nothing is accepted, then written to the buffer.
// A packet of n buffered bytes is then sent as the header, the optional timestamp, and for
// each data byte a registered read of the buffer and a load of the output.
// A sysex end byte with bytes pending sends that packet, writes the end byte and sends it
// as a second packet; with sixteen entries this is the longest beat.
// Reset clears the fill count and control state; buffer contents are never cleared.
// A stalled output holds the sequencer in the header, stamp and data states; s_tready is high only while idle.
//
// Top level of the MIDI to BLE packet framer; depends on mbf_pkg, mbf_buffer and the
// assertion macro header.
`timescale 1ns / 1ps
`include "midi_byte_to_ble_packet_framer_macros.svh"
module midi_byte_to_ble_packet_framer
	import mbf_pkg::*;
#(
	parameter int BUFFER_BYTES = MBF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] midi_byte, [20:8] time_ms, [23:21] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast,   // packet_end
	output logic        m_tuser    // [0] run_last
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int IW = $clog2(BUFFER_BYTES);

	// The sequencer: one state per kind of work, one output beat at most per state visit.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_HDR,
		ST_STAMP,
		ST_RD,
		ST_DAT
	} state_t;

	state_t        state_q;
	logic [7:0]    byte_q;      // latched midi byte
	logic [12:0]   time_q;      // latched millisecond time
	logic [CW-1:0] count_q;     // bytes held in the buffer
	logic [IW-1:0] idx_q;       // read index while a packet is sent
	logic [7:0]    first_q;     // copy of buffer entry zero
	logic          more_q;      // another packet follows the one being sent
	logic [7:0]    out_byte_q;
	logic          out_end_q;
	logic          out_last_q;
	logic          out_valid_q;

	logic          in_beat;
	logic          out_free;
	logic          out_load;
	logic          wrap;
	logic [CW-1:0] base;
	logic [CW-1:0] opnd;
	logic [CW-1:0] inc;
	logic          at_end;
	logic [7:0]    first_new;
	logic [1:0]    need;
	logic          do_flush;
	logic [7:0]    rd_data;

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	// The output register takes a new beat whenever a sending state finds it free.
	assign out_load = out_free
		&& (state_q == ST_HDR || state_q == ST_STAMP || state_q == ST_DAT);

	// Write slot: a full buffer starts again at entry zero.
	assign wrap = (count_q >= CW'(BUFFER_BYTES));
	assign base = wrap ? '0 : count_q;

	// The shared incrementer and compare: it bumps the fill count while writing and the
	// read index while sending, and the same compare finds the final data byte.
	assign opnd   = (state_q == ST_WRITE) ? base : CW'(idx_q);
	assign inc    = opnd + CW'(1);
	assign at_end = (inc == count_q);

	// The first byte decides the message length; it is the new byte when entry zero is written.
	assign first_new = (base == '0) ? byte_q : first_q;
	assign need      = mbf_msg_length(first_new);
	assign do_flush  = ((need != 2'd0) && (inc == CW'(need))) || (inc >= CW'(BUFFER_BYTES));

	mbf_buffer #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_buffer (
		.clk       (clk),
		.wr_en     (state_q == ST_WRITE),
		.wr_addr   (base[IW-1:0]),
		.wr_data   (byte_q),
		.rd_en     (state_q == ST_RD),
		.rd_addr   (idx_q),
		.rd_data_q (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_q      <= '0;
			time_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			first_q     <= '0;
			more_q      <= 1'b0;
			out_byte_q  <= '0;
			out_end_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						byte_q <= s_tdata[7:0];
						time_q <= s_tdata[20:8];
						// A sysex end byte first sends what is pending as a packet of its own.
						if (s_tdata[7:0] == MBF_SYSEX_END && count_q != '0) begin
							more_q  <= 1'b1;
							state_q <= ST_HDR;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					count_q <= inc;
					first_q <= first_new;
					state_q <= do_flush ? ST_HDR : ST_IDLE;
				end
				ST_HDR: begin
					if (out_free) begin
						out_byte_q  <= MBF_HDR_MARK | {2'b00, time_q[12:7]};
						out_end_q   <= 1'b0;
						out_last_q  <= 1'b0;
						idx_q       <= '0;
						state_q     <= first_q[7] ? ST_STAMP : ST_RD;
					end
				end
				ST_STAMP: begin
					if (out_free) begin
						out_byte_q  <= MBF_HDR_MARK | {1'b0, time_q[6:0]};
						out_end_q   <= 1'b0;
						out_last_q  <= 1'b0;
						state_q     <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DAT;
				end
				ST_DAT: begin
					if (out_free) begin
						out_byte_q  <= rd_data;
						out_end_q   <= at_end;
						out_last_q  <= at_end && !more_q;
						if (at_end) begin
							count_q <= '0;
							more_q  <= 1'b0;
							// After the flush ahead of a sysex end, that byte is written next.
							state_q <= more_q ? ST_WRITE : ST_IDLE;
						end else begin
							idx_q   <= inc[IW-1:0];
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_last_q;

	// The fill count never runs past the buffer size.
	`MBF_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(BUFFER_BYTES), "fill count overflow")
	// The final result of an input beat is always the final byte of a packet.
	`MBF_ASSERT_NOW(a_last_ends_packet, m_tvalid && m_tuser, m_tlast, "run_last without packet_end")
	// The read index stays inside the filled part of the buffer while data is sent.
	`MBF_ASSERT_NOW(a_idx_in_fill, state_q == ST_DAT, CW'(idx_q) < count_q, "read index past fill")
	// An accepted beat always takes the block out of idle.
	`MBF_ASSERT_NEXT(a_busy_after_beat, in_beat, state_q != ST_IDLE, "idle after accepted beat")

endmodule

// ===== rtl/mbf_buffer.sv =====
// Pending byte store of the framer: one write port, one registered read port.
// Depends on mbf_pkg.
`timescale 1ns / 1ps
module mbf_buffer
	import mbf_pkg::*;
#(
	parameter int BUFFER_BYTES = MBF_BUFFER_BYTES,
	localparam int IW = $clog2(BUFFER_BYTES)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [7:0]    rd_data_q
);

	logic [7:0] mem_q [BUFFER_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

// ===== tb/tb_midi_byte_to_ble_packet_framer.sv =====
// Self-checking testbench for the MIDI byte to BLE MIDI packet framer.
// It holds a directed table and random traffic, checked beat by beat against a built-in predictor.
// Depends on mbf_pkg and the framer RTL.
`timescale 1ns / 1ps
module tb_midi_byte_to_ble_packet_framer
	import mbf_pkg::*;
();

	// MIDI status bytes that the stimulus and the length decode refer to.
	localparam logic [7:0] ST_NOTE_OFF     = 8'h80;
	localparam logic [7:0] ST_CTRL_LAST    = 8'hBF;
	localparam logic [7:0] ST_PROGRAM      = 8'hC0;
	localparam logic [7:0] ST_PRESS_LAST   = 8'hDF;
	localparam logic [7:0] ST_BEND_FIRST   = 8'hE0;
	localparam logic [7:0] ST_BEND_LAST    = 8'hEF;
	localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
	localparam logic [7:0] ST_TIME_CODE    = 8'hF1;
	localparam logic [7:0] ST_SONG_POS     = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
	localparam logic [7:0] ST_SINGLE_FIRST = 8'hF4;
	localparam logic [7:0] ST_SYS_RESET    = 8'hFF;
	localparam logic [7:0] DATA_MAX        = 8'h7F;

	localparam int RANDOM_ITEMS  = 286;
	localparam int CALM_ITEMS    = 40;   // the closing stretch of random traffic has no idling
	localparam int LONG_HOLD     = 300;  // cycles the receiver holds off in one go
	localparam int HOLD_AT       = 60;
	localparam int PAUSE_AT      = 150;
	localparam int TAIL_CYCLES   = 64;   // longer than the slowest packet the block can send
	localparam int WATCHDOG_MAX  = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [7:0] midi_byte, [20:8] time_ms, [23:21] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] packet_byte
	logic        m_tlast;   // packet_end
	logic        m_tuser;   // [0] run_last

	midi_byte_to_ble_packet_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// One beat of an outgoing packet, as the predictor expects it.
	typedef struct packed {
		logic [7:0] packet_byte;
		logic       packet_end;
		logic       run_last;
	} packet_beat_t;

	// A row of the directed table. When spot_checked is set, packet_beats holds the three beats
	// of a single stamped packet, the header in the lowest byte, and the predictor must agree.
	typedef struct packed {
		logic [7:0]  midi_byte;
		logic [12:0] time_ms;
		logic        spot_checked;
		logic [23:0] packet_beats;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 25;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Both time extremes on one-byte messages, read straight off the packet layout.
		'{ST_SYS_RESET,     13'h1FFF, 1'b1, 24'hFF_FF_BF},
		'{ST_TIME_CODE,     13'h0000, 1'b1, 24'hF1_80_80},
		// A lone sysex end with nothing pending is a one-byte message of its own.
		'{MBF_SYSEX_END,    13'h0000, 1'b1, 24'hF7_80_80},
		'{ST_SINGLE_FIRST,  13'h0080, 1'b1, 24'hF4_80_81},
		// Two-byte messages.
		'{ST_PROGRAM,       13'h0005, 1'b0, 24'h0},
		'{DATA_MAX,         13'h0006, 1'b0, 24'h0},
		'{ST_SONG_SEL,      13'h0FFF, 1'b0, 24'h0},
		'{8'h55,            13'h0FFF, 1'b0, 24'h0},
		// Three-byte messages at both ends of the lower range and at the top of the pitch-bend range.
		'{ST_NOTE_OFF,      13'h0080, 1'b0, 24'h0},
		'{8'h01,            13'h0081, 1'b0, 24'h0},
		'{DATA_MAX,         13'h0082, 1'b0, 24'h0},
		'{ST_CTRL_LAST,     13'h1F80, 1'b0, 24'h0},
		'{8'h2A,            13'h1F81, 1'b0, 24'h0},
		'{8'h00,            13'h1F82, 1'b0, 24'h0},
		'{ST_BEND_LAST,     13'h007F, 1'b0, 24'h0},
		'{8'h40,            13'h0100, 1'b0, 24'h0},
		'{8'h3F,            13'h0101, 1'b0, 24'h0},
		'{ST_SONG_POS,      13'h1555, 1'b0, 24'h0},
		'{8'h00,            13'h0AAA, 1'b0, 24'h0},
		'{DATA_MAX,         13'h1555, 1'b0, 24'h0},
		// Sysex: the end byte first flushes what is pending, then goes out alone.
		'{ST_SYSEX_START,   13'h0333, 1'b0, 24'h0},
		'{8'h12,            13'h0334, 1'b0, 24'h0},
		'{MBF_SYSEX_END,    13'h0335, 1'b0, 24'h0},
		// Data with no status in front: the flushed packet carries no timestamp.
		'{8'h00,            13'h1234, 1'b0, 24'h0},
		'{MBF_SYSEX_END,    13'h1235, 1'b0, 24'h0}
	};

	// Predictor state: its own copy of the buffered bytes and their count.
	logic [7:0]   held_bytes [MBF_BUFFER_BYTES];
	int unsigned  held_count;
	packet_beat_t step_beats [$];     // beats caused by the latest accepted input byte
	packet_beat_t awaited_beats [$];  // beats still to come out of the block, oldest first

	int  mismatches;
	int  random_sent;
	bit  calm;
	bit  long_hold_req;
	int  idle_cycles;

	// Message length given by the first byte of the buffer; zero means it never completes.
	function automatic int unsigned msg_span(input logic [7:0] s);
		if (s >= ST_SINGLE_FIRST || s == ST_TIME_CODE) return 1;
		if ((s >= ST_PROGRAM && s <= ST_PRESS_LAST) || s == ST_SONG_SEL) return 2;
		if ((s >= ST_NOTE_OFF && s <= ST_CTRL_LAST) || (s >= ST_BEND_FIRST && s <= ST_BEND_LAST)
				|| s == ST_SONG_POS) return 3;
		return 0;
	endfunction

	function automatic void emit_beat(input logic [7:0] b, input logic last_of_packet);
		packet_beat_t beat;
		beat.packet_byte = b;
		beat.packet_end  = last_of_packet;
		beat.run_last    = 1'b0;
		step_beats.push_back(beat);
	endfunction

	// Sends everything held as one packet: header, timestamp if a status byte leads, data.
	function automatic void flush_held(input logic [12:0] t);
		int unsigned i;
		if (held_count == 0) return;
		emit_beat(MBF_HDR_MARK | {2'b00, t[12:7]}, 1'b0);
		if (held_bytes[0][7]) emit_beat(MBF_HDR_MARK | {1'b0, t[6:0]}, 1'b0);
		for (i = 0; i < held_count; i++) emit_beat(held_bytes[i], i + 1 == held_count);
		held_count = 0;
	endfunction

	// Works out the beats that one accepted MIDI byte causes and queues them.
	function automatic void frame_byte(input logic [7:0] b, input logic [12:0] t);
		int unsigned span;
		int k;
		step_beats.delete();
		if (b == MBF_SYSEX_END && held_count > 0) flush_held(t);
		if (held_count >= MBF_BUFFER_BYTES) held_count = 0;
		held_bytes[held_count] = b;
		held_count++;
		span = msg_span(held_bytes[0]);
		if (span != 0 && held_count == span) flush_held(t);
		if (held_count >= MBF_BUFFER_BYTES) flush_held(t);
		if (step_beats.size() > 0) begin
			k = step_beats.size() - 1;
			step_beats[k].run_last = 1'b1;
		end
		foreach (step_beats[j]) awaited_beats.push_back(step_beats[j]);
	endfunction

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Reset is asserted once, at the start of the run.
	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random stalls in bursts, one long hold-off on request, none in the calm stretch.
	// The long hold-off is counted here, so the sender keeps offering while the block backs up.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Output checker: every accepted beat is compared with the oldest one awaited.
	always @(posedge clk) begin
		packet_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_beats.size() == 0) begin
				mismatches++;
				$display("%0t: beat with nothing awaited: byte %02h end %0b last %0b",
					$time, m_tdata, m_tlast, m_tuser);
			end else begin
				want = awaited_beats.pop_front();
				if (m_tdata !== want.packet_byte || m_tlast !== want.packet_end
						|| m_tuser !== want.run_last) begin
					mismatches++;
					$display("%0t: beat mismatch: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
						$time, want.packet_byte, want.packet_end, want.run_last,
						m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	// Watchdog: too long without a beat on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_MAX) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// Offers one MIDI byte and waits for the block to take it, then predicts what it causes.
	// Afterwards the sender may drop valid for a random burst of cycles.
	task automatic offer(input logic [7:0] b, input logic [12:0] t);
		s_tdata  <= {3'b000, t, b};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		frame_byte(b, t);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// One random-part beat, with a random time and the pressure points along the way.
	task automatic send_random(input logic [7:0] b);
		offer(b, 13'($urandom_range(0, 8191)));
		random_sent++;
		calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
		if (random_sent == HOLD_AT) long_hold_req = 1'b1;
		if (random_sent == PAUSE_AT) begin
			// The sender holds back until the block has delivered everything.
			s_tvalid <= 1'b0;
			do @(posedge clk); while (awaited_beats.size() != 0);
		end
	endtask

	task automatic send_data_run(input int count);
		repeat (count) send_random(8'($urandom_range(0, DATA_MAX)));
	endtask

	// Random traffic: mostly well-formed messages and sysex with random content, some data
	// runs long enough to fill the buffer, some cut-off messages and some plain noise.
	task automatic random_traffic();
		int kind;
		logic [7:0] status;
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				status = 8'($urandom_range(ST_NOTE_OFF, ST_SYS_RESET));
				send_random(status);
				if (msg_span(status) > 1) send_data_run(msg_span(status) - 1);
			end else if (kind <= 5) begin
				// Sysex; a long payload can fill the buffer and flush it with a timestamp.
				send_random(ST_SYSEX_START);
				send_data_run(($urandom_range(0, 3) == 0) ? $urandom_range(13, 20)
					: $urandom_range(0, 12));
				if ($urandom_range(0, 5) != 0) send_random(MBF_SYSEX_END);
			end else if (kind == 6) begin
				send_data_run($urandom_range(1, 20));
				if ($urandom_range(0, 1) == 0) send_random(MBF_SYSEX_END);
			end else if (kind == 7) begin
				// A three-byte message cut short by whatever follows.
				send_random(8'($urandom_range(ST_NOTE_OFF, ST_CTRL_LAST)));
				send_data_run(1);
			end else begin
				repeat ($urandom_range(1, 4)) send_random(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Stimulus: the directed table first, then random traffic, then the drain and the verdict.
	initial begin : sender
		int r;
		int k;
		mismatches    = 0;
		random_sent   = 0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles   = 0;
		held_count    = 0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			offer(directed_rows[r].midi_byte, directed_rows[r].time_ms);
			if (directed_rows[r].spot_checked) begin
				// The predictor must produce the hand-worked packet for this row.
				if (step_beats.size() != 3) begin
					mismatches++;
					$display("%0t: row %0d: expected 3 beats, predicted %0d",
						$time, r, step_beats.size());
				end else begin
					for (k = 0; k < 3; k++) begin
						if (step_beats[k].packet_byte !== directed_rows[r].packet_beats[8*k +: 8]
								|| step_beats[k].packet_end !== (k == 2)
								|| step_beats[k].run_last !== (k == 2)) begin
							mismatches++;
							$display("%0t: row %0d beat %0d: expected byte %02h, predicted %02h",
								$time, r, k, directed_rows[r].packet_beats[8*k +: 8],
								step_beats[k].packet_byte);
						end
					end
				end
			end
		end

		random_traffic();

		s_tvalid <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
		// Any beat that still turns up now is flagged by the checker as unexpected.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbf_pkg.sv
rtl/mbf_buffer.sv
rtl/midi_byte_to_ble_packet_framer.sv
tb/tb_midi_byte_to_ble_packet_framer.sv
